@@ rtl/core/ugb_pkg.sv @@
package ugb_pkg;

    // default build of the grid
    localparam int GRID_DIM_DEF        = 64;
    localparam int GUESTS_PER_CELL_DEF = 4;
    localparam int MAX_GROUPS_DEF      = 15;
    localparam int ID_BITS_DEF         = 16;

    // most results one neighbor query may return
    localparam int MAX_RESULTS = 36;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 3'd4;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_STATE  = 2'd2;
    localparam logic [1:0] FUNC_NEIGH  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic [15:0]        agent_id;
        logic [3:0]         group_id;
        logic [5:0]         cell_x;
        logic [5:0]         cell_z;
        logic               search_range;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  out_cell_x;
        logic [5:0]  out_cell_z;
        logic [11:0] cell_index;
        logic [4:0]  cell_code;
        logic        in_mixed_cell;
        logic        cell_overflow;
        logic        out_of_grid;
        logic [15:0] neighbor_id;
        logic        neighbor_valid;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOC,
        S_INS_RD,
        S_QRY,
        S_QRY_RD,
        S_NB_CELL,
        S_NB_CNT,
        S_NB_GRD,
        S_NB_GCMP,
        S_NB_END,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        LOC_IDLE,
        LOC_MUL,
        LOC_CHK
    } loc_state_t;

endpackage

@@ rtl/core/ugb_if.sv @@
interface ugb_in_if
    import ugb_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ugb_out_if
    import ugb_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/uniform_grid_binning_neighbor_query.sv @@
// Uniform grid binning with neighbor query. Commands arrive one at a time on cmd and
// their results leave on res, which has its own output register so a new command is
// taken while a result still waits. Cell counts and state codes live in one
// synchronous RAM of GRID_DIM*GRID_DIM words, guest ids in a second RAM of
// GUESTS_PER_CELL slots per cell; an insert walks the cell RAM through a read,
// then a write in the next cycle. An insert first runs the position to cell step, which
// takes x and z in turn through one shared 32x32 multiplier, then one cell read and
// write; a state query reads one cell word when the cell lies in the grid; a
// neighbor query reads the cell word of each window cell inside the grid and then
// each stored guest, up to nine cells; a clear zeroes one cell word per cycle. A
// held result on res stalls the walk only when a new result must pass it. The
// same clearing pass runs after reset: cmd stays not ready until every cell word
// is zeroed, while configuration writes are taken as ever.
module uniform_grid_binning_neighbor_query
    import ugb_pkg::*;
#(
    parameter int GRID_DIM        = GRID_DIM_DEF,
    parameter int GUESTS_PER_CELL = GUESTS_PER_CELL_DEF,
    parameter int MAX_GROUPS      = MAX_GROUPS_DEF,
    parameter int ID_BITS         = ID_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ugb_in_if.sink                cmd,
    ugb_out_if.source             res
);

    localparam int NCELLS  = GRID_DIM * GRID_DIM;
    localparam int CW      = $clog2(GRID_DIM);
    localparam int DW      = ($clog2(GRID_DIM + 1) > 7) ? $clog2(GRID_DIM + 1) : 7;
    localparam int NW      = DW + 1;
    localparam int IDX_W   = $clog2(NCELLS);
    localparam int GA_W    = $clog2(NCELLS * GUESTS_PER_CELL);
    localparam int CNT_W   = $clog2(GUESTS_PER_CELL + 1);
    localparam int CODE_W  = $clog2(MAX_GROUPS + 2);
    localparam int CELL_W  = CNT_W + CODE_W;
    localparam int SW      = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int FOUND_W = $clog2(MAX_RESULTS + 1);
    localparam logic [CODE_W-1:0] MIXED = CODE_W'(MAX_GROUPS + 1);

    // configuration
    logic [31:0] min_x_reg, min_z_reg, inv_reg;
    logic [6:0]  num_cols_reg, num_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg    <= 32'd0;
            min_z_reg    <= 32'd0;
            inv_reg      <= 32'd65536;
            num_cols_reg <= 7'd64;
            num_rows_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X:    min_x_reg    <= cfg_data;
                REG_MIN_Z:    min_z_reg    <= cfg_data;
                REG_INV_CELL: inv_reg      <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data[6:0];
                REG_NUM_ROWS: num_rows_reg <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // clamp the dimensions in use to the built grid
    logic [DW-1:0] cols, rows;
    assign cols = (DW'(num_cols_reg) > DW'(GRID_DIM)) ? DW'(GRID_DIM) : DW'(num_cols_reg);
    assign rows = (DW'(num_rows_reg) > DW'(GRID_DIM)) ? DW'(GRID_DIM) : DW'(num_rows_reg);

    // control and item state
    state_t          state_reg, state_next;
    in_item_t        item_reg, item_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    logic            clr_reply_reg, clr_reply_next;
    logic [CW-1:0]   cur_x_reg, cur_x_next;
    logic [CW-1:0]   cur_z_reg, cur_z_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic signed [1:0] dx_reg, dx_next;
    logic signed [1:0] dz_reg, dz_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    out_item_t       pend_reg, pend_next;
    logic            pend_valid_reg, pend_valid_next;
    out_item_t       res_reg, res_next;
    out_item_t       out_reg, out_next;
    logic            out_valid_reg;
    logic            out_load;
    logic            can_load;

    // memories
    logic              c_we, c_re;
    logic [IDX_W-1:0]  c_waddr, c_raddr;
    logic [CELL_W-1:0] c_wdata, c_rdata;
    logic              g_we, g_re;
    logic [GA_W-1:0]   g_waddr, g_raddr;
    logic [SW-1:0]     g_wdata, g_rdata;

    ugb_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_cell_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    ugb_ram #(.WIDTH(SW), .DEPTH(NCELLS * GUESTS_PER_CELL)) u_guest_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // position to cell
    logic          loc_start, loc_done, loc_oog;
    logic [CW-1:0] loc_cx, loc_cz;

    ugb_locate #(.GRID_DIM(GRID_DIM), .CW(CW), .DW(DW)) u_locate (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (loc_start),
        .pos_x         (cmd.data.pos_x),
        .pos_z         (cmd.data.pos_z),
        .min_x         (min_x_reg),
        .min_z         (min_z_reg),
        .inv_cell_size (inv_reg),
        .cols          (cols),
        .rows          (rows),
        .done          (loc_done),
        .oog           (loc_oog),
        .cx            (loc_cx),
        .cz            (loc_cz)
    );

    // window walk: column and row of the current window cell
    logic signed [NW-1:0] wx, wz;
    logic                 win_in, win_last;
    logic signed [1:0]    rng;
    logic [DW-1:0]        qx, qz;

    assign qx  = DW'(item_reg.cell_x);
    assign qz  = DW'(item_reg.cell_z);
    assign rng = item_reg.search_range ? 2'sd1 : 2'sd0;
    assign wx  = $signed({1'b0, qx}) + NW'(dx_reg);
    assign wz  = $signed({1'b0, qz}) + NW'(dz_reg);
    assign win_in = !wx[NW-1] && !wz[NW-1] && (wx[DW-1:0] < cols) && (wz[DW-1:0] < rows);
    assign win_last = (dx_reg == rng) && (dz_reg == rng);

    // row-major index of the selected cell
    logic [CW-1:0]       cx_sel, cz_sel;
    logic [CW+DW-1:0]    idx_wide;
    logic [IDX_W-1:0]    idx_calc;

    always_comb
    begin
        case (state_reg)
            S_LOC:
            begin
                cx_sel = loc_cx;
                cz_sel = loc_cz;
            end
            S_NB_CELL:
            begin
                cx_sel = CW'(wx[DW-1:0]);
                cz_sel = CW'(wz[DW-1:0]);
            end
            default:
            begin
                cx_sel = CW'(item_reg.cell_x);
                cz_sel = CW'(item_reg.cell_z);
            end
        endcase
        idx_wide = cz_sel * cols + (CW + DW)'(cx_sel);
        idx_calc = idx_wide[IDX_W-1:0];
    end

    // cell word fields and insert update
    logic [CNT_W-1:0]  c_cnt;
    logic [CODE_W-1:0] c_code, grp_code, new_code;
    logic              grp_ok;
    logic [GA_W-1:0]   slot_base;

    assign c_cnt    = c_rdata[CELL_W-1:CODE_W];
    assign c_code   = c_rdata[CODE_W-1:0];
    assign grp_code = CODE_W'({1'b0, item_reg.group_id} + 5'd1);
    assign grp_ok   = (32'(item_reg.group_id) < MAX_GROUPS)
                      && ((c_code == '0) || (c_code == grp_code));
    assign new_code = grp_ok ? grp_code : MIXED;
    assign slot_base = GA_W'(cur_idx_reg) * GA_W'(GUESTS_PER_CELL);

    assign can_load = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    logic hit;
    assign hit = (item_reg.agent_id < 16'(g_rdata)) && (32'(found_reg) < MAX_RESULTS);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        clr_addr_next   = clr_addr_reg;
        clr_reply_next  = clr_reply_reg;
        cur_x_next      = cur_x_reg;
        cur_z_next      = cur_z_reg;
        cur_idx_next    = cur_idx_reg;
        dx_next         = dx_reg;
        dz_next         = dz_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        found_next      = found_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        out_load        = 1'b0;
        out_next        = res_reg;
        loc_start       = 1'b0;
        c_we            = 1'b0;
        c_waddr         = cur_idx_reg;
        c_wdata         = '0;
        c_re            = 1'b0;
        c_raddr         = idx_calc;
        g_we            = 1'b0;
        g_waddr         = slot_base + GA_W'(c_cnt);
        g_wdata         = SW'(item_reg.agent_id);
        g_re            = 1'b0;
        g_raddr         = slot_base + GA_W'(k_reg);

        case (state_reg)
            S_CLEAR:
            begin
                // zero one cell word per cycle
                c_we    = 1'b1;
                c_waddr = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(NCELLS - 1))
                begin
                    clr_reply_next = 1'b0;
                    if (clr_reply_reg)
                    begin
                        res_next      = '0;
                        res_next.last = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    item_next = cmd.data;
                    case (cmd.data.func)
                        FUNC_CLEAR:
                        begin
                            clr_addr_next  = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        FUNC_INSERT:
                        begin
                            loc_start  = 1'b1;
                            state_next = S_LOC;
                        end
                        FUNC_STATE:
                        begin
                            state_next = S_QRY;
                        end
                        default:
                        begin
                            dx_next         = cmd.data.search_range ? -2'sd1 : 2'sd0;
                            dz_next         = cmd.data.search_range ? -2'sd1 : 2'sd0;
                            found_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_NB_CELL;
                        end
                    endcase
                end
            end
            S_LOC:
            begin
                if (loc_done)
                begin
                    if (loc_oog)
                    begin
                        res_next             = '0;
                        res_next.out_of_grid = 1'b1;
                        res_next.last        = 1'b1;
                        state_next           = S_EMIT;
                    end
                    else
                    begin
                        cur_x_next   = loc_cx;
                        cur_z_next   = loc_cz;
                        cur_idx_next = idx_calc;
                        c_re         = 1'b1;
                        state_next   = S_INS_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                // append the id when a slot is free; the state updates either way
                res_next = '0;
                if (32'(c_cnt) < GUESTS_PER_CELL)
                begin
                    g_we    = 1'b1;
                    c_wdata = {c_cnt + CNT_W'(1), new_code};
                end
                else
                begin
                    res_next.cell_overflow = 1'b1;
                    c_wdata = {c_cnt, new_code};
                end
                c_we                   = 1'b1;
                res_next.out_cell_x    = 6'(cur_x_reg);
                res_next.out_cell_z    = 6'(cur_z_reg);
                res_next.cell_index    = 12'(cur_idx_reg);
                res_next.cell_code     = 5'(new_code);
                res_next.in_mixed_cell = (new_code == MIXED);
                res_next.last          = 1'b1;
                state_next             = S_EMIT;
            end
            S_QRY:
            begin
                if ((qx >= cols) || (qz >= rows))
                begin
                    res_next             = '0;
                    res_next.out_cell_x  = item_reg.cell_x;
                    res_next.out_cell_z  = item_reg.cell_z;
                    res_next.out_of_grid = 1'b1;
                    res_next.last        = 1'b1;
                    state_next           = S_EMIT;
                end
                else
                begin
                    cur_idx_next = idx_calc;
                    c_re         = 1'b1;
                    state_next   = S_QRY_RD;
                end
            end
            S_QRY_RD:
            begin
                res_next               = '0;
                res_next.out_cell_x    = item_reg.cell_x;
                res_next.out_cell_z    = item_reg.cell_z;
                res_next.cell_index    = 12'(cur_idx_reg);
                res_next.cell_code     = 5'(c_code);
                res_next.in_mixed_cell = (c_code == MIXED);
                res_next.last          = 1'b1;
                state_next             = S_EMIT;
            end
            S_NB_CELL:
            begin
                if (win_in)
                begin
                    cur_x_next   = CW'(wx[DW-1:0]);
                    cur_z_next   = CW'(wz[DW-1:0]);
                    cur_idx_next = idx_calc;
                    c_re         = 1'b1;
                    state_next   = S_NB_CNT;
                end
                else if (win_last)
                begin
                    state_next = S_NB_END;
                end
                else if (dz_reg == rng)
                begin
                    dz_next = -rng;
                    dx_next = dx_reg + 2'sd1;
                end
                else
                begin
                    dz_next = dz_reg + 2'sd1;
                end
            end
            S_NB_CNT:
            begin
                n_next     = c_cnt;
                k_next     = '0;
                state_next = S_NB_GRD;
            end
            S_NB_GRD:
            begin
                if (k_reg < n_reg)
                begin
                    g_re       = 1'b1;
                    state_next = S_NB_GCMP;
                end
                else if (win_last)
                begin
                    state_next = S_NB_END;
                end
                else
                begin
                    if (dz_reg == rng)
                    begin
                        dz_next = -rng;
                        dx_next = dx_reg + 2'sd1;
                    end
                    else
                    begin
                        dz_next = dz_reg + 2'sd1;
                    end
                    state_next = S_NB_CELL;
                end
            end
            S_NB_GCMP:
            begin
                // a hit pushes out the held one, which is then known not to be last
                if (!(hit && pend_valid_reg && !can_load))
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_next = pend_reg;
                        end
                        pend_next                = '0;
                        pend_next.out_cell_x     = 6'(cur_x_reg);
                        pend_next.out_cell_z     = 6'(cur_z_reg);
                        pend_next.cell_index     = 12'(cur_idx_reg);
                        pend_next.neighbor_id    = 16'(g_rdata);
                        pend_next.neighbor_valid = 1'b1;
                        pend_valid_next          = 1'b1;
                        found_next               = found_reg + FOUND_W'(1);
                    end
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_NB_GRD;
                end
            end
            S_NB_END:
            begin
                if (pend_valid_reg)
                begin
                    res_next = pend_reg;
                end
                else
                begin
                    res_next = '0;
                end
                res_next.last = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_reply_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_reply_reg  <= clr_reply_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cur_x_reg   <= cur_x_next;
        cur_z_reg   <= cur_z_next;
        cur_idx_reg <= cur_idx_next;
        dx_reg      <= dx_next;
        dz_reg      <= dz_next;
        k_reg       <= k_next;
        n_reg       <= n_next;
        found_reg   <= found_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

endmodule

@@ rtl/core/ugb_ram.sv @@
module ugb_ram
    import ugb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/ugb_locate.sv @@
module ugb_locate
    import ugb_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF,
    parameter int CW       = $clog2(GRID_DIM),
    parameter int DW       = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   pos_x,
    input  logic [31:0]   pos_z,
    input  logic [31:0]   min_x,
    input  logic [31:0]   min_z,
    input  logic [31:0]   inv_cell_size,
    input  logic [DW-1:0] cols,
    input  logic [DW-1:0] rows,
    output logic          done,
    output logic          oog,
    output logic [CW-1:0] cx,
    output logic [CW-1:0] cz
);

    loc_state_t  st_reg, st_next;
    logic        axis_reg, axis_next;
    logic [32:0] dx_reg, dx_next;
    logic [32:0] dz_reg, dz_next;
    logic [63:0] prod_reg, prod_next;
    logic        done_reg, done_next;
    logic        oog_reg, oog_next;
    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] cz_reg, cz_next;

    logic [32:0]   d_sel;
    logic [DW-1:0] lim;
    logic [31:0]   q;
    logic          bad;

    always_comb
    begin
        st_next   = st_reg;
        axis_next = axis_reg;
        dx_next   = dx_reg;
        dz_next   = dz_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        oog_next  = oog_reg;
        cx_next   = cx_reg;
        cz_next   = cz_reg;
        d_sel     = axis_reg ? dz_reg : dx_reg;
        lim       = axis_reg ? rows : cols;
        q         = prod_reg[63:32];
        // the difference never exceeds 32 magnitude bits, so bit 32 is the sign
        bad       = d_sel[32] || (q >= 32'(lim));
        case (st_reg)
            LOC_IDLE:
            begin
                if (start)
                begin
                    dx_next   = {pos_x[31], pos_x} - {min_x[31], min_x};
                    dz_next   = {pos_z[31], pos_z} - {min_z[31], min_z};
                    axis_next = 1'b0;
                    oog_next  = 1'b0;
                    st_next   = LOC_MUL;
                end
            end
            LOC_MUL:
            begin
                prod_next = d_sel[31:0] * inv_cell_size;
                st_next   = LOC_CHK;
            end
            LOC_CHK:
            begin
                oog_next = oog_reg | bad;
                if (!axis_reg)
                begin
                    cx_next   = q[CW-1:0];
                    axis_next = 1'b1;
                    st_next   = LOC_MUL;
                end
                else
                begin
                    cz_next   = q[CW-1:0];
                    done_next = 1'b1;
                    st_next   = LOC_IDLE;
                end
            end
            default:
            begin
                st_next = LOC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= LOC_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
        dx_reg   <= dx_next;
        dz_reg   <= dz_next;
        prod_reg <= prod_next;
        oog_reg  <= oog_next;
        cx_reg   <= cx_next;
        cz_reg   <= cz_next;
    end

    assign done = done_reg;
    assign oog  = oog_reg;
    assign cx   = cx_reg;
    assign cz   = cz_reg;

endmodule
